@@ hw/rtl/oaht_pkg.sv @@
`default_nettype none
package oaht_pkg;

  // field widths
  localparam int KEY_W   = 32;
  localparam int ATT_W   = 7;
  localparam int OUTC_W  = 2;
  localparam int COEF_W  = 8;
  localparam int MOD_W   = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODULUS = 2'd3;

  localparam logic              RST_PROBE_MODE   = 1'b0;
  localparam logic [COEF_W-1:0] RST_LINEAR_COEF  = 8'd1;
  localparam logic [COEF_W-1:0] RST_SQUARE_COEF  = 8'd1;
  localparam logic [MOD_W-1:0]  RST_STEP_MODULUS = 7'd7;

  // probe mode codes
  localparam logic MODE_QUADRATIC = 1'b0;
  localparam logic MODE_DOUBLE    = 1'b1;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_INSERTED   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_REMOVED    = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_NOT_PLACED = 2'd2;

  // serial remainder: digit width and digit counts
  localparam int DIGIT_W      = 4;
  localparam int KEY_DIGITS   = KEY_W / DIGIT_W;
  localparam int SMALL_DIGITS = COEF_W / DIGIT_W;

  // default sizes
  localparam int DEF_TABLE_SIZE   = 128;
  localparam int DEF_MAX_ATTEMPTS = 99;

endpackage
`default_nettype wire

@@ hw/rtl/oaht_ram.sv @@
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/open_addressing_hash_toggle_core.sv @@
// open-addressing hash table whose keys toggle membership
//
// input channel: in_valid / in_ready with one key per beat. each key is
// inserted at the first empty slot along its probe sequence, or removed if
// the same key is met in a full slot first. output channel: out_valid /
// out_ready, one beat per key with the probe count and the outcome.
// probe sequence is quadratic or double hashing, chosen by probe_mode.
// config writes (cfg_write, cfg_index, cfg_data) take effect at once and
// are expected only while the block is idle.
//
// after reset the block sweeps the slot memory once, marking every slot
// empty, and in_ready stays low during the sweep.
// one key at a time: a digit-serial remainder (key mod table size, key mod
// step modulus), reduction of the probe step and coefficients, a setup
// step, then per probe one read of the slot memory and one check and
// write-back, and a finish step to hand over the result.
// the result sits in an output register, so a stalled receiver holds only
// the next key's finish: the next key is accepted and worked on meanwhile.
`default_nettype none
module open_addressing_hash_toggle_core
  import oaht_pkg::*;
#(
  parameter int TABLE_SIZE   = DEF_TABLE_SIZE,
  parameter int MAX_ATTEMPTS = DEF_MAX_ATTEMPTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // key channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [KEY_W-1:0]      key,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [ATT_W-1:0]      attempts,
  output logic      [OUTC_W-1:0]     outcome
);

  localparam int TW    = $clog2(TABLE_SIZE);          // slot index width
  localparam int CW    = $clog2(MAX_ATTEMPTS + 1);    // probe counter width
  localparam int DCW   = $clog2(KEY_DIGITS);          // digit counter width
  localparam int RAM_W = KEY_W + 1;                   // {empty, key}

  // sequencer codes
  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SRED  = 3'd3;
  localparam logic [2:0] ST_SETUP = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_CHK   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  // modular add of two slot-range values
  function automatic logic [TW-1:0] add_mod(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (TW+1)'(TABLE_SIZE)) begin
      sum = sum - (TW+1)'(TABLE_SIZE);
    end
    return sum[TW-1:0];
  endfunction

  // one digit of remainder by table size
  function automatic logic [TW-1:0] red_t(input logic [TW-1:0] r, input logic [DIGIT_W-1:0] dig);
    logic [TW:0]   tmp;
    logic [TW-1:0] acc;
    acc = r;
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      tmp = {acc, dig[j]};
      if (tmp >= (TW+1)'(TABLE_SIZE)) begin
        tmp = tmp - (TW+1)'(TABLE_SIZE);
      end
      acc = tmp[TW-1:0];
    end
    return acc;
  endfunction

  // one digit of remainder by the step modulus
  function automatic logic [MOD_W-1:0] red_r(input logic [MOD_W-1:0] r,
                                             input logic [DIGIT_W-1:0] dig,
                                             input logic [MOD_W-1:0] dv);
    logic [MOD_W:0]   tmp;
    logic [MOD_W-1:0] acc;
    acc = r;
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      tmp = {acc, dig[j]};
      if (tmp >= {1'b0, dv}) begin
        tmp = tmp - {1'b0, dv};
      end
      acc = tmp[MOD_W-1:0];
    end
    return acc;
  endfunction

  // config registers
  logic              probe_mode;
  logic [COEF_W-1:0] linear_coef;
  logic [COEF_W-1:0] square_coef;
  logic [MOD_W-1:0]  step_modulus;
  logic [MOD_W-1:0]  r_eff;

  // sequencer and datapath registers
  logic [2:0]         state;
  logic [TW-1:0]      clr_addr;
  logic [DCW-1:0]     dig_cnt;
  logic [KEY_W-1:0]   key_q;
  logic [KEY_W-1:0]   key_sh;
  logic [TW-1:0]      home;
  logic [MOD_W-1:0]   kr;
  logic [MOD_W-1:0]   kr_next;
  logic [COEF_W-1:0]  step_sh;
  logic [COEF_W-1:0]  c1_sh;
  logic [COEF_W-1:0]  c2_sh;
  logic [TW-1:0]      step_m;
  logic [TW-1:0]      c1_m;
  logic [TW-1:0]      c2_m;
  logic [TW-1:0]      slot;
  logic [TW-1:0]      dlt;
  logic [TW-1:0]      ddl;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_inc;
  logic [CW+ATT_W-1:0] att_wide;
  logic [ATT_W-1:0]   res_att;
  logic [OUTC_W-1:0]  res_out;

  // slot memory
  logic             ram_we;
  logic [TW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;
  logic             slot_empty;
  logic             slot_match;
  logic             out_free;

  oaht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // a zero modulus acts as one
  assign r_eff = (step_modulus == '0) ? MOD_W'(1) : step_modulus;

  assign slot_empty = ram_rdata[KEY_W];
  assign slot_match = (ram_rdata[KEY_W-1:0] == key_q);
  assign cnt_inc    = cnt + CW'(1);
  assign att_wide   = {{ATT_W{1'b0}}, cnt_inc};
  assign kr_next    = red_r(kr, key_sh[KEY_W-1 -: DIGIT_W], r_eff);
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE);

  // write-back: clearing pass, insert (empty cleared) or removal (empty set)
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = {~slot_empty, key_q};
    if (state == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = {1'b1, {KEY_W{1'b0}}};
    end else if (state == ST_CHK) begin
      ram_we = slot_empty || slot_match;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode   <= RST_PROBE_MODE;
      linear_coef  <= RST_LINEAR_COEF;
      square_coef  <= RST_SQUARE_COEF;
      step_modulus <= RST_STEP_MODULUS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROBE_MODE:   probe_mode   <= cfg_data[0];
        REG_LINEAR_COEF:  linear_coef  <= cfg_data;
        REG_SQUARE_COEF:  square_coef  <= cfg_data;
        REG_STEP_MODULUS: step_modulus <= cfg_data[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      dig_cnt  <= '0;
    end else begin
      unique case (state)
        ST_CLR: begin
          // one slot per cycle marked empty
          clr_addr <= clr_addr + TW'(1);
          if (clr_addr == TW'(TABLE_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state   <= ST_DIV;
            dig_cnt <= '0;
          end
        end
        ST_DIV: begin
          // key mod table size and key mod step modulus, a digit a cycle
          if (dig_cnt == DCW'(KEY_DIGITS - 1)) begin
            state   <= ST_SRED;
            dig_cnt <= '0;
          end else begin
            dig_cnt <= dig_cnt + DCW'(1);
          end
        end
        ST_SRED: begin
          dig_cnt <= dig_cnt + DCW'(1);
          if (dig_cnt == DCW'(SMALL_DIGITS - 1)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: state <= ST_RD;
        ST_RD:    state <= ST_CHK;
        ST_CHK: begin
          if (slot_empty || slot_match || cnt_inc == CW'(MAX_ATTEMPTS)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLR;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key_q  <= key;
        key_sh <= key;
        home   <= '0;
        kr     <= '0;
        c1_sh  <= linear_coef;
        c2_sh  <= square_coef;
        step_m <= '0;
        c1_m   <= '0;
        c2_m   <= '0;
      end
      ST_DIV: begin
        home   <= red_t(home, key_sh[KEY_W-1 -: DIGIT_W]);
        kr     <= kr_next;
        key_sh <= key_sh << DIGIT_W;
        // probe step for double hashing, 1..R
        step_sh <= {1'b0, r_eff - kr_next};
      end
      ST_SRED: begin
        // step and coefficients brought into slot range
        step_m  <= red_t(step_m, step_sh[COEF_W-1 -: DIGIT_W]);
        c1_m    <= red_t(c1_m, c1_sh[COEF_W-1 -: DIGIT_W]);
        c2_m    <= red_t(c2_m, c2_sh[COEF_W-1 -: DIGIT_W]);
        step_sh <= step_sh << DIGIT_W;
        c1_sh   <= c1_sh << DIGIT_W;
        c2_sh   <= c2_sh << DIGIT_W;
      end
      ST_SETUP: begin
        slot <= home;
        cnt  <= '0;
        if (probe_mode == MODE_DOUBLE) begin
          dlt <= step_m;
          ddl <= '0;
        end else begin
          // quadratic offset differences: c1 + c2*(2i+1), growing by 2*c2
          dlt <= add_mod(c1_m, c2_m);
          ddl <= add_mod(c2_m, c2_m);
        end
      end
      ST_CHK: begin
        res_att <= att_wide[ATT_W-1:0];
        if (slot_empty) begin
          res_out <= OUTC_INSERTED;
        end else if (slot_match) begin
          res_out <= OUTC_REMOVED;
        end else begin
          res_out <= OUTC_NOT_PLACED;
          slot    <= add_mod(slot, dlt);
          dlt     <= add_mod(dlt, ddl);
          cnt     <= cnt_inc;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      attempts <= res_att;
      outcome  <= res_out;
    end
  end

  // memory writes only during the clearing pass or a probe check
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLR || state == ST_CHK))
    else $error("slot memory written outside clear or check");

  // a result is only raised from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside finish");

  // probe counter stays below the limit while probing
  a_probe_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD || state == ST_CHK) |-> cnt < CW'(MAX_ATTEMPTS))
    else $error("probe count past limit");

  // probed slot stays inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> slot <= TW'(TABLE_SIZE - 1))
    else $error("slot index out of range");

  // an accepted key starts the remainder phase
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_DIV && dig_cnt == '0))
    else $error("accepted key did not start");

endmodule
`default_nettype wire

@@ bench/open_addressing_hash_toggle_core_tb.sv @@
module open_addressing_hash_toggle_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  localparam int SLOTS       = DEF_TABLE_SIZE;
  localparam int PROBE_LIMIT = DEF_MAX_ATTEMPTS;
  localparam int STALL_MAX   = 16;
  // longest quiet stretch: clearing sweep after reset, or a key that runs
  // all its probes plus both sides stalling, many times over
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASES      = 10;
  localparam int PHASE_KEYS  = 115;
  localparam int POOL_SIZE   = 40;
  localparam int HOT_HOMES   = 6;

  // one result beat: probe count and outcome
  typedef struct packed {
    logic [ATT_W-1:0]  attempts;
    logic [OUTC_W-1:0] outcome;
  } toggle_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [KEY_W-1:0]      key;
  logic                  out_valid;
  logic                  out_ready;
  logic [ATT_W-1:0]      attempts;
  logic [OUTC_W-1:0]     outcome;

  // mirror of the slot memory and the register file
  logic [KEY_W-1:0]  mirror_key [SLOTS];
  bit                mirror_free [SLOTS];
  logic              cur_mode;
  logic [COEF_W-1:0] cur_linear;
  logic [COEF_W-1:0] cur_square;
  logic [MOD_W-1:0]  cur_modulus;

  // results still owed by the block, oldest first
  toggle_result_t owed_results [$];

  // stimulus knobs
  bit               send_idles;
  bit               recv_idles;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               failures;
  int               quiet_cycles;

  open_addressing_hash_toggle_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .attempts  (attempts),
    .outcome   (outcome)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // every slot empty, registers at their reset values
  function automatic void clear_mirror();
    for (int s = 0; s < SLOTS; s++) begin
      mirror_key[s]  = '0;
      mirror_free[s] = 1'b1;
    end
    cur_mode    = RST_PROBE_MODE;
    cur_linear  = RST_LINEAR_COEF;
    cur_square  = RST_SQUARE_COEF;
    cur_modulus = RST_STEP_MODULUS;
  endfunction

  // walk the probe sequence of one key, toggle its membership in the mirror
  // and return the beat the block should produce for it
  function automatic toggle_result_t toggle_key(input logic [KEY_W-1:0] k);
    int unsigned    home;
    int unsigned    modv;
    int unsigned    step;
    int unsigned    offset;
    int unsigned    slot;
    bit             done;
    toggle_result_t res;
    home = k % SLOTS;
    // a zero modulus behaves as one, giving a unit step
    modv = (cur_modulus == '0) ? 1 : cur_modulus;
    step = modv - (k % modv);
    res.attempts = ATT_W'(PROBE_LIMIT);
    res.outcome  = OUTC_NOT_PLACED;
    done = 1'b0;
    for (int i = 0; i < PROBE_LIMIT && !done; i++) begin
      if (cur_mode == MODE_DOUBLE) begin
        offset = i * step;
      end else begin
        offset = cur_linear * i + cur_square * i * i;
      end
      slot = (home + offset) % SLOTS;
      if (mirror_free[slot]) begin
        // first empty slot takes the key; a removed slot is a plain hole
        mirror_key[slot]  = k;
        mirror_free[slot] = 1'b0;
        res.attempts = ATT_W'(i + 1);
        res.outcome  = OUTC_INSERTED;
        done = 1'b1;
      end else if (mirror_key[slot] == k) begin
        mirror_free[slot] = 1'b1;
        res.attempts = ATT_W'(i + 1);
        res.outcome  = OUTC_REMOVED;
        done = 1'b1;
      end
    end
    return res;
  endfunction

  // one key beat; valid stays up until the block takes it
  task automatic send_key(input logic [KEY_W-1:0] k);
    int gap;
    gap = send_idles ? $urandom_range(0, STALL_MAX) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    owed_results.push_back(toggle_key(k));
  endtask

  // drop valid and hold off until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PROBE_MODE:   cur_mode    = val[0];
      REG_LINEAR_COEF:  cur_linear  = val[COEF_W-1:0];
      REG_SQUARE_COEF:  cur_square  = val[COEF_W-1:0];
      REG_STEP_MODULUS: cur_modulus = val[MOD_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers, only once the block has gone quiet
  task automatic set_config(input logic mode, input logic [COEF_W-1:0] lin,
                            input logic [COEF_W-1:0] sq, input logic [MOD_W-1:0] modv);
    wait_drained();
    write_reg(REG_PROBE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_LINEAR_COEF, lin);
    write_reg(REG_SQUARE_COEF, sq);
    write_reg(REG_STEP_MODULUS, CFG_DATA_W'(modv));
  endtask

  // mostly keys that crowd a few home slots, so toggles and long probe
  // chains are common; some fully random keys keep every bit moving
  function automatic logic [KEY_W-1:0] next_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic void refill_pool();
    logic [6:0] hot [HOT_HOMES];
    for (int h = 0; h < HOT_HOMES; h++) hot[h] = 7'($urandom_range(0, SLOTS - 1));
    for (int p = 0; p < POOL_SIZE; p++) begin
      key_pool[p] = ($urandom() & 32'hFFFF_FF80) | hot[$urandom_range(0, HOT_HOMES - 1)];
    end
  endfunction

  // default quadratic probe: collisions at one home, removal and the hole it
  // leaves, keys at both ends of the range and wraparound past the last slot
  task automatic test_home_collisions();
    send_key(32'h0000_0000);
    send_key(32'h0000_0080);
    send_key(32'h0000_0000);
    send_key(32'h0000_0100);
    send_key(32'h0000_0080);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h7FFF_FFFF);
  endtask

  // zero coefficients pin every probe to home, so a second key there runs
  // out of attempts and leaves the table as it was; then both at maximum
  task automatic test_probe_limit();
    set_config(MODE_QUADRATIC, 8'd0, 8'd0, RST_STEP_MODULUS);
    send_key(32'h0000_0005);
    send_key(32'h0000_0085);
    send_key(32'h0000_0005);
    set_config(MODE_QUADRATIC, 8'd255, 8'd255, RST_STEP_MODULUS);
    send_key(32'hAAAA_AA80);
    send_key(32'h5555_5500);
  endtask

  // double hashing: zero modulus acting as one, a step of half the table
  // that visits only two slots, and the largest modulus
  task automatic test_double_hashing();
    set_config(MODE_DOUBLE, 8'd1, 8'd1, 7'd0);
    send_key(32'h0000_0100);
    send_key(32'h0000_0180);
    set_config(MODE_DOUBLE, 8'd1, 8'd1, 7'd64);
    send_key(32'h0000_0200);
    send_key(32'h0000_0240);
    send_key(32'h0000_0280);
    set_config(MODE_DOUBLE, 8'd1, 8'd1, 7'd127);
    send_key(32'hFFFF_FF00);
    send_key(32'h1234_5600);
  endtask

  // phases of random keys, each under its own register setting and idling mix
  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(MODE_QUADRATIC, RST_LINEAR_COEF, RST_SQUARE_COEF, RST_STEP_MODULUS);
        1: set_config(MODE_QUADRATIC, 8'd0, 8'd0, 7'($urandom_range(1, 127)));
        2: set_config(MODE_QUADRATIC, 8'd255, 8'd255, 7'd127);
        3: set_config(MODE_DOUBLE, 8'($urandom()), 8'($urandom()), 7'd127);
        4: set_config(MODE_DOUBLE, 8'($urandom()), 8'($urandom()), 7'd1);
        5: set_config(MODE_DOUBLE, 8'($urandom()), 8'($urandom()), 7'd0);
        6: set_config(MODE_QUADRATIC, 8'd2, 8'd0, 7'($urandom_range(1, 127)));
        7: set_config(MODE_DOUBLE, 8'($urandom()), 8'($urandom()),
                      7'($urandom_range(1, 127)));
        default: set_config(1'($urandom()), 8'($urandom()), 8'($urandom()),
                            7'($urandom_range(0, 127)));
      endcase
      send_idles = (p % 3 != 1);
      recv_idles = (p % 4 != 2);
      refill_pool();
      for (int n = 0; n < PHASE_KEYS; n++) begin
        // sender holds back once until the block has emptied out
        if (p == 4 && n == PHASE_KEYS / 2) wait_drained();
        send_key(next_key());
      end
    end
  endtask

  // result side: random ready stalls, each beat checked against the oldest
  // owed result
  initial begin
    int             gap;
    toggle_result_t want;
    out_ready = 1'b0;
    forever begin
      gap = recv_idles ? $urandom_range(0, STALL_MAX) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1 || rst) @(posedge clk);
      if (owed_results.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing owed, got attempts %0d outcome %0d",
                 $time, attempts, outcome);
      end else begin
        want = owed_results.pop_front();
        if (attempts !== want.attempts) begin
          failures++;
          $display("%0t: attempts expected %0d got %0d", $time, want.attempts, attempts);
        end
        if (outcome !== want.outcome) begin
          failures++;
          $display("%0t: outcome expected %0d got %0d", $time, want.outcome, outcome);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    key          = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_PROBE_MODE;
    cfg_data     = '0;
    send_idles   = 1'b1;
    recv_idles   = 1'b1;
    failures     = 0;
    quiet_cycles = 0;
    clear_mirror();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_home_collisions();
    test_probe_limit();
    test_double_hashing();
    test_random_phases();

    // all keys in; let the last results drain and watch for strays
    wait_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/open_addressing_hash_toggle_core.sv
bench/open_addressing_hash_toggle_core_tb.sv
